>>> hdl/spm_pkg.sv
// Shared constants, codes and control types for the sparse page map.
package spm_pkg;

	// Slots per node; fixed as a power of two so slot and tag are plain bit fields
	localparam int FANOUT_LOG2 = 4;
	localparam int FANOUT      = 1 << FANOUT_LOG2;

	// Defaults for the top-level parameters
	localparam int NODE_COUNT_DEF  = 16;
	localparam int PAGE_SHIFT_DEF  = 12;
	localparam int OFFSET_BITS_DEF = 48;
	localparam int FRAME_BITS_DEF  = 32;

	// Freed page count, saturating
	localparam int              COUNT_W   = 9;
	localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

	typedef enum logic [1:0] {
		ACT_ADD      = 2'd0,
		ACT_GET      = 2'd1,
		ACT_FREE_ALL = 2'd2
	} action_t;

	typedef enum logic [1:0] {
		STS_OK        = 2'd0,
		STS_EXISTS    = 2'd1,
		STS_NO_ROOM   = 2'd2,
		STS_NOT_FOUND = 2'd3
	} resp_code_t;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_SEARCH,
		ST_SLOT_RD,
		ST_SLOT_CHK,
		ST_SWEEP,
		ST_SWEEP_TAIL,
		ST_RESP
	} state_t;

	// Sequencer to node unit
	typedef struct packed {
		logic start;
		logic claim;
		logic clear_all;
	} node_ctrl_t;

	// Node unit back to sequencer
	typedef struct packed {
		logic done;
		logic hit;
		logic free_ok;
	} node_flags_t;

endpackage

>>> hdl/spm_node_unit.sv
// Node tag store with a single comparator that walks the nodes one per cycle.
module spm_node_unit #(
	parameter int NODE_COUNT = spm_pkg::NODE_COUNT_DEF,
	parameter int TAG_W      = 32,
	parameter int NODE_W     = 4
) (
	input  logic               clk,
	input  logic               arst_n,
	input  spm_pkg::node_ctrl_t ctrl,
	input  logic [TAG_W-1:0]   tag,
	output spm_pkg::node_flags_t flags,
	output logic [NODE_W-1:0]  hit_idx,
	output logic [NODE_W-1:0]  free_idx
);
	import spm_pkg::*;

	localparam logic [NODE_W-1:0] LAST = NODE_W'(NODE_COUNT - 1);

	logic [TAG_W-1:0]      tag_mem [NODE_COUNT];
	logic [NODE_COUNT-1:0] used_q;

	logic              issue_q;
	logic [NODE_W-1:0] n_q;
	logic              live_s1;
	logic [NODE_W-1:0] n_s1;
	logic              last_s1;
	logic [TAG_W-1:0]  tag_rd_s1;
	logic              free_ok_q;
	logic [NODE_W-1:0] free_idx_q;

	logic hit;
	logic cur_free;

	// Compare stage
	assign hit      = live_s1 && used_q[n_s1] && (tag_rd_s1 == tag);
	assign cur_free = live_s1 && !used_q[n_s1];

	assign flags.done    = live_s1 && (hit || last_s1);
	assign flags.hit     = hit;
	assign flags.free_ok = free_ok_q || cur_free;
	assign hit_idx       = n_s1;
	assign free_idx      = free_ok_q ? free_idx_q : n_s1;

	// Tag memory: claim writes at the first free node, search reads one node a cycle
	always_ff @(posedge clk) begin
		if (ctrl.claim) begin
			tag_mem[free_idx] <= tag;
		end
		tag_rd_s1 <= tag_mem[n_q];
	end

	// Used bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			used_q <= '0;
		end else if (ctrl.clear_all) begin
			used_q <= '0;
		end else if (ctrl.claim) begin
			used_q[free_idx] <= 1'b1;
		end
	end

	// Walk control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			issue_q   <= 1'b0;
			n_q       <= '0;
			live_s1   <= 1'b0;
			n_s1      <= '0;
			last_s1   <= 1'b0;
			free_ok_q <= 1'b0;
		end else if (ctrl.start) begin
			issue_q   <= 1'b1;
			n_q       <= '0;
			live_s1   <= 1'b0;
			free_ok_q <= 1'b0;
		end else begin
			// stop at the first match or after the last node
			live_s1 <= issue_q && !flags.done;
			n_s1    <= n_q;
			last_s1 <= (n_q == LAST);
			if (flags.done) begin
				issue_q <= 1'b0;
			end else if (issue_q) begin
				if (n_q == LAST) begin
					issue_q <= 1'b0;
				end else begin
					n_q <= n_q + 1'b1;
				end
			end
			if (cur_free && !free_ok_q) begin
				free_ok_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cur_free && !free_ok_q) begin
			free_idx_q <= n_s1;
		end
	end

endmodule

>>> hdl/spm_slot_ram.sv
// Slot store: valid bit plus frame per slot, one write and one registered read a cycle.
module spm_slot_ram #(
	parameter int DEPTH  = 256,
	parameter int ADDR_W = 8,
	parameter int DATA_W = 33
) (
	input  logic              clk,
	input  logic              we,
	input  logic [ADDR_W-1:0] waddr,
	input  logic [DATA_W-1:0] wdata,
	input  logic              re,
	input  logic [ADDR_W-1:0] raddr,
	output logic [DATA_W-1:0] rdata
);
	logic [DATA_W-1:0] mem [DEPTH];

	// Read returns the old word when both ports hit one address
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

>>> hdl/sparse_page_map_unit.sv
// Add/get: one tag comparator steps one node per cycle; on a hit or a claimed node the
// slot is read and checked, while a miss with no node claimed goes straight to the result.
// Free all: one slot read, counted and cleared per cycle.
// One request at a time: in_ready returns the cycle after the result is loaded.
// Reset: node bits clear at once, then a clearing pass over all NODE_COUNT*FANOUT slots
// (256 by default) zeroes the slot store while in_ready stays low.
module sparse_page_map_unit #(
	parameter int NODE_COUNT  = spm_pkg::NODE_COUNT_DEF,
	parameter int PAGE_SHIFT  = spm_pkg::PAGE_SHIFT_DEF,
	parameter int OFFSET_BITS = spm_pkg::OFFSET_BITS_DEF,
	parameter int FRAME_BITS  = spm_pkg::FRAME_BITS_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  logic [1:0]                  action,
	input  logic [OFFSET_BITS-1:0]      offset,
	input  logic [FRAME_BITS-1:0]       page_frame,
	output logic                        out_valid,
	input  logic                        out_ready,
	output logic [1:0]                  status,
	output logic [FRAME_BITS-1:0]       frame_out,
	output logic [spm_pkg::COUNT_W-1:0] freed_count
);
	import spm_pkg::*;

	localparam int NODE_W     = (NODE_COUNT > 1) ? $clog2(NODE_COUNT) : 1;
	localparam int SLOT_TOTAL = NODE_COUNT * FANOUT;
	localparam int SLOT_AW    = $clog2(SLOT_TOTAL);
	localparam int TAG_LO     = PAGE_SHIFT + FANOUT_LOG2;
	localparam int TAG_W      = OFFSET_BITS - TAG_LO;
	localparam int WORD_W     = FRAME_BITS + 1;
	localparam logic [SLOT_AW-1:0] K_LAST = SLOT_AW'(SLOT_TOTAL - 1);

	state_t state_q, state_d;

	// Request registers
	action_t               act_q;
	logic [TAG_W-1:0]       tag_q;
	logic [FANOUT_LOG2-1:0] slot_q;
	logic [FRAME_BITS-1:0]  frame_q;
	logic [NODE_W-1:0]      node_q;

	// Result being built
	resp_code_t            res_status_q;
	logic [FRAME_BITS-1:0] res_frame_q;
	logic [COUNT_W-1:0]    res_freed_q;
	logic [COUNT_W-1:0]    count_q, count_d;

	// Sweep
	logic [SLOT_AW-1:0] k_q;
	logic               rd_live_q;

	// Output register
	logic                  out_valid_q;
	resp_code_t            status_q;
	logic [FRAME_BITS-1:0] frame_out_q;
	logic [COUNT_W-1:0]    freed_q;

	node_ctrl_t        node_ctrl;
	node_flags_t       node_flags;
	logic [NODE_W-1:0] hit_idx;
	logic [NODE_W-1:0] free_idx;

	logic               ram_we, ram_re;
	logic [SLOT_AW-1:0] ram_waddr, ram_raddr, item_addr;
	logic [WORD_W-1:0]  ram_wdata, ram_rdata;
	logic               resp_load;
	logic               accept;
	logic               slot_valid;

	assign accept     = in_valid && in_ready;
	assign item_addr  = SLOT_AW'({node_q, slot_q});
	assign slot_valid = ram_rdata[FRAME_BITS];

	assign out_valid   = out_valid_q;
	assign status      = status_q;
	assign frame_out   = frame_out_q;
	assign freed_count = freed_q;

	spm_node_unit #(
		.NODE_COUNT(NODE_COUNT),
		.TAG_W     (TAG_W),
		.NODE_W    (NODE_W)
	) u_node (
		.clk     (clk),
		.arst_n  (arst_n),
		.ctrl    (node_ctrl),
		.tag     (tag_q),
		.flags   (node_flags),
		.hit_idx (hit_idx),
		.free_idx(free_idx)
	);

	spm_slot_ram #(
		.DEPTH (SLOT_TOTAL),
		.ADDR_W(SLOT_AW),
		.DATA_W(WORD_W)
	) u_slots (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.re   (ram_re),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	// Saturating count of filled slots seen by the sweep
	always_comb begin
		count_d = count_q;
		if (rd_live_q && slot_valid && (count_q != COUNT_MAX)) begin
			count_d = count_q + 1'b1;
		end
	end

	// Sequencer: next state and unit controls
	always_comb begin
		state_d   = state_q;
		in_ready  = 1'b0;
		node_ctrl = '0;
		ram_we    = 1'b0;
		ram_waddr = item_addr;
		ram_wdata = '0;
		ram_re    = 1'b0;
		ram_raddr = item_addr;
		resp_load = 1'b0;
		case (state_q)
			ST_CLEAR: begin
				ram_we    = 1'b1;
				ram_waddr = k_q;
				if (k_q == K_LAST) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					case (action)
						ACT_ADD, ACT_GET: begin
							node_ctrl.start = 1'b1;
							state_d         = ST_SEARCH;
						end
						ACT_FREE_ALL: state_d = ST_SWEEP;
						default:      state_d = ST_RESP;
					endcase
				end
			end
			ST_SEARCH: begin
				if (node_flags.done) begin
					if (node_flags.hit) begin
						state_d = ST_SLOT_RD;
					end else if (act_q == ACT_ADD && node_flags.free_ok) begin
						node_ctrl.claim = 1'b1;
						state_d         = ST_SLOT_RD;
					end else begin
						state_d = ST_RESP;
					end
				end
			end
			ST_SLOT_RD: begin
				ram_re  = 1'b1;
				state_d = ST_SLOT_CHK;
			end
			ST_SLOT_CHK: begin
				if (act_q == ACT_ADD && !slot_valid) begin
					ram_we    = 1'b1;
					ram_wdata = {1'b1, frame_q};
				end
				state_d = ST_RESP;
			end
			ST_SWEEP: begin
				ram_re    = 1'b1;
				ram_raddr = k_q;
				ram_we    = 1'b1;
				ram_waddr = k_q;
				if (k_q == K_LAST) begin
					state_d = ST_SWEEP_TAIL;
				end
			end
			ST_SWEEP_TAIL: begin
				node_ctrl.clear_all = 1'b1;
				state_d             = ST_RESP;
			end
			ST_RESP: begin
				if (!out_valid_q || out_ready) begin
					resp_load = 1'b1;
					state_d   = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// Control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			k_q         <= '0;
			rd_live_q   <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q   <= state_d;
			rd_live_q <= (state_q == ST_SWEEP);
			if (state_q == ST_CLEAR || state_q == ST_SWEEP) begin
				k_q <= (k_q == K_LAST) ? '0 : k_q + 1'b1;
			end
			if (resp_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Request and result datapath
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					act_q        <= action_t'(action);
					tag_q        <= offset[OFFSET_BITS-1:TAG_LO];
					slot_q       <= offset[TAG_LO-1:PAGE_SHIFT];
					frame_q      <= page_frame;
					res_status_q <= STS_OK;
					res_frame_q  <= '0;
					res_freed_q  <= '0;
					count_q      <= '0;
				end
			end
			ST_SEARCH: begin
				if (node_flags.done) begin
					if (node_flags.hit) begin
						node_q <= hit_idx;
					end else if (act_q == ACT_ADD && node_flags.free_ok) begin
						node_q <= free_idx;
					end else if (act_q == ACT_GET) begin
						res_status_q <= STS_NOT_FOUND;
					end else begin
						res_status_q <= STS_NO_ROOM;
					end
				end
			end
			ST_SLOT_CHK: begin
				if (act_q == ACT_GET) begin
					if (slot_valid) begin
						res_frame_q <= ram_rdata[FRAME_BITS-1:0];
					end else begin
						res_status_q <= STS_NOT_FOUND;
					end
				end else if (slot_valid) begin
					res_status_q <= STS_EXISTS;
				end
			end
			ST_SWEEP: begin
				count_q <= count_d;
			end
			ST_SWEEP_TAIL: begin
				count_q     <= count_d;
				res_freed_q <= count_d;
			end
			ST_RESP: begin
				if (resp_load) begin
					status_q    <= res_status_q;
					frame_out_q <= res_frame_q;
					freed_q     <= res_freed_q;
				end
			end
			default: ;
		endcase
	end

`ifndef SYNTH
	// Taking a request makes the block busy on the next cycle
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> !in_ready)
		else $error("in_ready high right after a request was taken");

	// The node search only finishes while the sequencer waits for it
	a_search_done_in_search: assert property (@(posedge clk) disable iff (!arst_n)
		node_flags.done |-> state_q == ST_SEARCH)
		else $error("node search finished outside the search state");

	// No slot write while idle or returning a result
	a_no_write_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_IDLE || state_q == ST_RESP) |-> !ram_we)
		else $error("slot store written while idle");

	// A nonzero freed count only comes with status ok and a zero frame
	a_freed_ok: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && freed_count != '0) |-> (status == STS_OK && frame_out == '0))
		else $error("freed count returned with a bad status or frame");
`endif

endmodule

>>> tb/tb.sv
// Self-checking testbench for the sparse page map unit: scoreboard, stimulus and handshake drivers.
`timescale 1ns / 100ps

module tb;
	import spm_pkg::*;

	localparam int OFF_W   = OFFSET_BITS_DEF;
	localparam int FRM_W   = FRAME_BITS_DEF;
	localparam int TAG_W   = OFF_W - PAGE_SHIFT_DEF - FANOUT_LOG2;
	localparam int NODES   = NODE_COUNT_DEF;
	localparam int SLOTS   = NODES * FANOUT;
	localparam int POOL_N  = 24;
	localparam int PER_PHASE  = 410;
	localparam int HOLD_LONG  = 400;
	localparam int TAIL_WAIT  = SLOTS + 16;
	localparam logic [1:0] ACT_UNUSED = 2'd3;

	// Idle percentages per phase: none, sender, receiver, both lightly
	localparam int SEND_IDLE[4] = '{0, 87, 0, 14};
	localparam int RECV_IDLE[4] = '{0, 0, 87, 14};

	typedef struct packed {
		resp_code_t         st;
		logic [FRM_W-1:0]   frm;
		logic [COUNT_W-1:0] cnt;
	} page_result_t;

	// Mirror of the page store plus the queue of results still owed by the block
	class page_map_board;
		logic [TAG_W-1:0] node_tags [NODES];
		bit               node_busy [NODES];
		bit               slot_full [SLOTS];
		logic [FRM_W-1:0] slot_frames [SLOTS];
		page_result_t     due_results [$];
		int errors, checked;
		int n_added, n_taken, n_no_room, n_missed, n_sweeps, top_sweep;

		function new();
			wipe();
			errors = 0; checked = 0;
			n_added = 0; n_taken = 0; n_no_room = 0; n_missed = 0;
			n_sweeps = 0; top_sweep = 0;
		endfunction

		function void wipe();
			for (int n = 0; n < NODES; n++) begin
				node_tags[n] = '0;
				node_busy[n] = 1'b0;
			end
			for (int k = 0; k < SLOTS; k++) begin
				slot_full[k] = 1'b0;
				slot_frames[k] = '0;
			end
		endfunction

		function int node_with_tag(logic [TAG_W-1:0] tag);
			for (int n = 0; n < NODES; n++)
				if (node_busy[n] && node_tags[n] == tag)
					return n;
			return -1;
		endfunction

		function int lowest_free_node();
			for (int n = 0; n < NODES; n++)
				if (!node_busy[n])
					return n;
			return -1;
		endfunction

		function int pending();
			return due_results.size();
		endfunction

		// Work out the result of one accepted request and queue it
		function void note_request(logic [1:0] act, logic [OFF_W-1:0] off,
		                           logic [FRM_W-1:0] frm);
			logic [TAG_W-1:0] tag;
			int slot, node, k;
			page_result_t r;
			tag  = off[OFF_W-1 -: TAG_W];
			slot = int'(off[PAGE_SHIFT_DEF +: FANOUT_LOG2]);
			r.st = STS_OK;
			r.frm = '0;
			r.cnt = '0;
			case (act)
				ACT_ADD: begin
					node = node_with_tag(tag);
					if (node < 0) begin
						node = lowest_free_node();
						if (node >= 0) begin
							node_busy[node] = 1'b1;
							node_tags[node] = tag;
						end
					end
					if (node < 0) begin
						r.st = STS_NO_ROOM;
						n_no_room++;
					end else begin
						k = node * FANOUT + slot;
						if (slot_full[k]) begin
							r.st = STS_EXISTS;
							n_taken++;
						end else begin
							slot_full[k] = 1'b1;
							slot_frames[k] = frm;
							n_added++;
						end
					end
				end
				ACT_GET: begin
					node = node_with_tag(tag);
					if (node >= 0 && slot_full[node * FANOUT + slot]) begin
						r.frm = slot_frames[node * FANOUT + slot];
					end else begin
						r.st = STS_NOT_FOUND;
						n_missed++;
					end
				end
				ACT_FREE_ALL: begin
					for (k = 0; k < SLOTS; k++)
						if (slot_full[k] && r.cnt != COUNT_MAX)
							r.cnt = r.cnt + 1'b1;
					wipe();
					n_sweeps++;
					if (int'(r.cnt) > top_sweep)
						top_sweep = int'(r.cnt);
				end
				default: ;  // spare code: no change, plain ok
			endcase
			due_results.push_back(r);
		endfunction

		// Compare one accepted result with the oldest one owed
		function void check_result(logic [1:0] st, logic [FRM_W-1:0] frm,
		                           logic [COUNT_W-1:0] cnt);
			page_result_t want;
			if (due_results.size() == 0) begin
				errors++;
				$display("%0t: unexpected result: status %0d frame %h count %0d",
				         $time, st, frm, cnt);
				return;
			end
			want = due_results.pop_front();
			checked++;
			if (st !== want.st) begin
				errors++;
				$display("%0t: status mismatch: expected %0d actual %0d", $time, want.st, st);
			end
			if (frm !== want.frm) begin
				errors++;
				$display("%0t: frame_out mismatch: expected %h actual %h", $time, want.frm, frm);
			end
			if (cnt !== want.cnt) begin
				errors++;
				$display("%0t: freed_count mismatch: expected %0d actual %0d",
				         $time, want.cnt, cnt);
			end
		endfunction
	endclass

	logic               clk;
	logic               arst_n;
	logic               in_valid;
	logic               in_ready;
	logic [1:0]         action;
	logic [OFF_W-1:0]   offset;
	logic [FRM_W-1:0]   page_frame;
	logic               out_valid;
	logic               out_ready;
	logic [1:0]         status;
	logic [FRM_W-1:0]   frame_out;
	logic [COUNT_W-1:0] freed_count;

	page_map_board    board;
	int               send_idle_pct;
	int               recv_idle_pct;
	int               hold_cycles;
	logic [TAG_W-1:0] tag_pool [POOL_N];
	logic [OFF_W-1:0] recent_offsets [$];

	sparse_page_map_unit uut (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.action      (action),
		.offset      (offset),
		.page_frame  (page_frame),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.status      (status),
		.frame_out   (frame_out),
		.freed_count (freed_count)
	);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	// Watch both handshakes at the rising edge
	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && in_ready)
				board.note_request(action, offset, page_frame);
			if (out_valid && out_ready)
				board.check_result(status, frame_out, freed_count);
		end
	end

	// Result side: random stalls, or a long hold-off when one is asked for
	initial begin
		out_ready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_cycles > 0) begin
				out_ready = 1'b0;
				hold_cycles--;
			end else begin
				out_ready = ($urandom_range(99) >= recv_idle_pct);
			end
		end
	end

	// Offer one request, holding it until taken; returns at a falling edge
	task automatic send_request(input logic [1:0] act, input logic [OFF_W-1:0] off,
	                            input logic [FRM_W-1:0] frm);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid = 1'b0;
			@(negedge clk);
		end
		in_valid = 1'b1;
		action = act;
		offset = off;
		page_frame = frm;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		@(negedge clk);
	endtask

	task automatic wait_all_results();
		in_valid = 1'b0;
		while (board.pending() != 0)
			@(negedge clk);
	endtask

	function automatic logic [OFF_W-1:0] make_offset(logic [TAG_W-1:0] tag, int slot);
		logic [PAGE_SHIFT_DEF-1:0] low;
		low = PAGE_SHIFT_DEF'($urandom);
		return {tag, slot[FANOUT_LOG2-1:0], low};
	endfunction

	// Zero and all-ones now and then, so both corners get stored
	function automatic logic [FRM_W-1:0] pick_frame();
		int r;
		r = $urandom_range(19);
		if (r == 0)
			return '0;
		if (r == 1)
			return '1;
		return $urandom;
	endfunction

	// Tags shared by the random requests; more than there are nodes
	function automatic void refill_pool();
		for (int i = 0; i < POOL_N; i++)
			tag_pool[i] = $urandom;
		tag_pool[0] = '0;
		tag_pool[1] = '1;
		tag_pool[2] = tag_pool[3] ^ 1;
	endfunction

	task automatic run_directed();
		send_request(ACT_GET, make_offset('0, 0), 32'h1234_5678);    // empty store
		send_request(ACT_ADD, make_offset('0, 0), '0);               // frame zero is real
		send_request(ACT_GET, make_offset('0, 0), '0);
		send_request(ACT_ADD, make_offset('0, 0), 32'hDEAD_BEEF);    // slot taken
		send_request(ACT_ADD, '1, '1);
		send_request(ACT_GET, '1, '0);
		send_request(ACT_GET, make_offset('0, 1), '0);               // node there, slot empty
		send_request(ACT_UNUSED, '1, '1);
		// fill the remaining nodes
		for (int n = 0; n < NODES - 2; n++)
			send_request(ACT_ADD, make_offset(32'h1 << n, n), pick_frame());
		send_request(ACT_ADD, make_offset(32'h8000_0000, 7), pick_frame());  // no node left
		send_request(ACT_GET, make_offset(32'h8000_0000, 7), '0);
		send_request(ACT_FREE_ALL, '0, '0);
	endtask

	// Every slot of every node filled, then swept: the full count
	task automatic fill_and_sweep();
		logic [TAG_W-1:0] base;
		base = $urandom;
		for (int n = 0; n < NODES; n++)
			for (int s = 0; s < FANOUT; s++)
				send_request(ACT_ADD, make_offset({base[TAG_W-1:4], n[3:0]}, s), pick_frame());
		send_request(ACT_FREE_ALL, make_offset(base, 0), pick_frame());
	endtask

	// Mostly adds and lookups on a small tag set, with noise and rare sweeps
	task automatic random_request();
		int r, r2, slot;
		logic [TAG_W-1:0] tag;
		logic [63:0] wide;
		logic [OFF_W-1:0] off;
		r = $urandom_range(999);
		r2 = $urandom_range(9);
		slot = $urandom_range(FANOUT - 1);
		tag = tag_pool[$urandom_range(POOL_N - 1)];
		wide = {$urandom, $urandom};
		if (r < 15) begin
			send_request(ACT_FREE_ALL, wide[OFF_W-1:0], pick_frame());
			recent_offsets.delete();
			refill_pool();
		end else if (r < 20) begin
			send_request(ACT_UNUSED, wide[OFF_W-1:0], pick_frame());
		end else if (r < 560) begin
			if (r2 == 0)
				off = wide[OFF_W-1:0];
			else
				off = make_offset(tag, slot);
			send_request(ACT_ADD, off, pick_frame());
			if (recent_offsets.size() >= 64)
				void'(recent_offsets.pop_front());
			recent_offsets.push_back(off);
		end else begin
			if (r2 < 6 && recent_offsets.size() > 0) begin
				off = recent_offsets[$urandom_range(recent_offsets.size() - 1)];
				off[PAGE_SHIFT_DEF-1:0] = PAGE_SHIFT_DEF'($urandom);
			end else if (r2 < 9) begin
				off = make_offset(tag, slot);
			end else begin
				off = wide[OFF_W-1:0];
			end
			send_request(ACT_GET, off, pick_frame());
		end
	endtask

	// Main sequence
	initial begin
		in_valid = 1'b0;
		action = ACT_ADD;
		offset = '0;
		page_frame = '0;
		send_idle_pct = 0;
		recv_idle_pct = 0;
		hold_cycles = 0;
		board = new();
		refill_pool();
		arst_n = 1'b0;
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		run_directed();
		wait_all_results();
		fill_and_sweep();
		wait_all_results();

		for (int ph = 0; ph < 4; ph++) begin
			send_idle_pct = SEND_IDLE[ph];
			recv_idle_pct = RECV_IDLE[ph];
			for (int i = 0; i < PER_PHASE; i++) begin
				// long result hold-off while requests keep coming
				if (ph == 0 && i == PER_PHASE / 2)
					hold_cycles = HOLD_LONG;
				random_request();
			end
			wait_all_results();
		end

		repeat (TAIL_WAIT) @(posedge clk);
		$display("Covered %0d results: %0d stored, %0d slot taken, %0d no node, %0d misses,",
		         board.checked, board.n_added, board.n_taken, board.n_no_room, board.n_missed);
		$display("and %0d sweeps (largest freed %0d) under four idle patterns.",
		         board.n_sweeps, board.top_sweep);
		if (board.errors == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

	// Timeout
	initial begin
		#50ms;
		$display("DONE: errors detected");
		$finish;
	end

endmodule
